>>> rtl/vpa_pkg.sv
// ----------------------------------------------------------------------------
// Variable partition allocator package
// Shared types and codes for the segment table allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam int unsigned SIZE_BITS = 16;
	localparam int unsigned OWNER_BITS = 8;
	localparam int unsigned ADDR_BITS = 16;
	localparam logic [15:0] RESET_TOTAL = 16'd1000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NO_OWNER = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_SPARE = 2'd3
	} policy_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_POLICY = 1'b0,
		REG_TOTAL  = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_MERGE,
		S_DONE
	} state_t;

endpackage

>>> rtl/variable_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// Variable partition allocator unit
// Segment table allocator with first, best and worst fit and coalescing.
// ----------------------------------------------------------------------------
// One request is taken while busy is low; its single result beat appears on
// status and address with done high for one cycle and cannot be stalled.
// Busy stays high while the scan walks the table; best and worst fit walk
// the whole table, while first fit or a free stops at the first match. A
// split then moves the entries above the chosen one up, one at a time. A free
// merges with a free right neighbor and then with a free left neighbor, and
// moves the entries above down for each neighbor it absorbs. The result beat
// appears in the same cycle in which busy falls. One
// compare unit walks the table one entry a cycle and one move path shifts
// one entry a cycle.
module variable_partition_allocator_unit #(
	parameter int unsigned MAX_SEGS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           opcode,
	input  logic [vpa_pkg::OWNER_BITS-1:0] owner_id,
	input  logic [15:0]                    req_size,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [15:0]                    address
);
	import vpa_pkg::*;

	localparam int unsigned IW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_SEGS);
	localparam logic [ADDR_BITS-1:0] AMASK = '1;

	logic [ADDR_BITS-1:0]  st_q [MAX_SEGS];
	logic [ADDR_BITS-1:0]  ln_q [MAX_SEGS];
	logic [OWNER_BITS-1:0] ow_q [MAX_SEGS];
	logic [MAX_SEGS-1:0]   used_q;
	logic [CW-1:0]         cnt_q;
	logic [1:0]            pol_q;

	state_t state_q, state_d;
	logic [CW-1:0]         i_q;
	logic [IW-1:0]         pick_q;
	logic                  found_q;
	logic                  op_q;
	logic [OWNER_BITS-1:0] own_q;
	logic [ADDR_BITS-1:0]  size_q;
	logic [1:0]            stat_q;
	logic [15:0]           addr_q;
	logic                  done_q;
	logic                  mphase_q;

	logic [IW-1:0]        ii;
	logic                 hit;
	logic                 better;
	logic                 fin;
	logic [ADDR_BITS-1:0] rq;
	logic                 merge_right;
	logic                 merge_left;

	assign ii = i_q[IW-1:0];
	assign rq = ADDR_BITS'(req_size) & AMASK;
	assign fin = (i_q >= cnt_q);
	assign hit = (op_q == OP_ALLOC) ? (!used_q[ii] && ln_q[ii] >= size_q)
	                                : (used_q[ii] && ow_q[ii] == own_q);
	assign merge_right = !mphase_q && (CW'(pick_q) + 1'b1 < cnt_q) &&
	                     !used_q[pick_q+1'b1];
	assign merge_left = (pick_q != '0) && !used_q[pick_q-1'b1];

	always_comb begin
		better = 1'b0;
		case (pol_q)
			POL_BEST:  better = ln_q[ii] < ln_q[pick_q];
			POL_WORST: better = ln_q[ii] > ln_q[pick_q];
			default:   better = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (start) state_d = S_SCAN;
			S_SCAN: begin
				if (fin) state_d = S_DECIDE;
				else if (hit && (op_q == OP_FREE || (!found_q &&
				         pol_q != POL_BEST && pol_q != POL_WORST)))
					state_d = S_DECIDE;
			end
			S_DECIDE:   state_d = S_DONE;
			S_SHIFT_UP: if (i_q <= CW'(pick_q) + 1'b1) state_d = S_DONE;
			S_SHIFT_DN: if (i_q + 1'b1 >= cnt_q) state_d = S_MERGE;
			S_MERGE:    state_d = (merge_right || merge_left) ? S_SHIFT_DN : S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
		if (state_q == S_DECIDE) begin
			if (op_q == OP_ALLOC && size_q != '0 && found_q &&
			    ln_q[pick_q] != size_q && cnt_q < CMAX)
				state_d = S_SHIFT_UP;
			else if (op_q == OP_FREE && found_q)
				state_d = S_MERGE;
		end
	end

	// Free merge runs as: merge with right (shift down), then with left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1);
			pol_q <= POL_FIRST;
			used_q <= '0;
			done_q <= 1'b0;
			i_q <= '0;
			found_q <= 1'b0;
			mphase_q <= 1'b0;
			op_q <= OP_ALLOC;
			own_q <= '0;
			size_q <= '0;
			pick_q <= '0;
			stat_q <= ST_OK;
			addr_q <= '0;
			for (int k = 0; k < MAX_SEGS; k++) begin
				st_q[k] <= '0;
				ln_q[k] <= (k == 0) ? ADDR_BITS'(RESET_TOTAL) : '0;
				ow_q[k] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we && state_q == S_IDLE) begin
				case (cfg_index)
					REG_POLICY: pol_q <= cfg_data[1:0];
					REG_TOTAL: begin
						cnt_q <= CW'(1);
						used_q <= '0;
						for (int k = 0; k < MAX_SEGS; k++) begin
							st_q[k] <= '0;
							ln_q[k] <= (k == 0) ? ADDR_BITS'(cfg_data) : '0;
							ow_q[k] <= '0;
						end
					end
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					op_q <= opcode;
					own_q <= owner_id;
					size_q <= rq;
					i_q <= '0;
					found_q <= 1'b0;
					pick_q <= '0;
					mphase_q <= 1'b0;
					stat_q <= ST_OK;
					addr_q <= '0;
				end
				S_SCAN: if (!fin) begin
					if (hit && (!found_q || better)) begin
						pick_q <= ii;
						found_q <= 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
				S_DECIDE: begin
					if (op_q == OP_ALLOC) begin
						if (size_q == '0 || !found_q) stat_q <= ST_NO_FIT;
						else if (ln_q[pick_q] == size_q) begin
							used_q[pick_q] <= 1'b1;
							ow_q[pick_q] <= own_q;
							addr_q <= 16'(st_q[pick_q]);
						end else if (cnt_q >= CMAX) stat_q <= ST_FULL;
						else begin
							addr_q <= 16'(st_q[pick_q]);
							i_q <= cnt_q;
						end
					end else if (!found_q) stat_q <= ST_NO_OWNER;
					else begin
						addr_q <= 16'(st_q[pick_q]);
						used_q[pick_q] <= 1'b0;
						ow_q[pick_q] <= '0;
					end
					if (size_q == '0 && op_q == OP_ALLOC) found_q <= 1'b0;
				end
				S_SHIFT_UP: begin
					ow_q[ii] <= ow_q[ii-1'b1];
					used_q[ii] <= used_q[ii-1'b1];
					if (i_q <= CW'(pick_q) + 1'b1) begin
						cnt_q <= cnt_q + 1'b1;
						used_q[pick_q] <= 1'b1;
						ow_q[pick_q] <= own_q;
						ln_q[pick_q] <= size_q;
						st_q[ii] <= st_q[pick_q] + size_q;
						ln_q[ii] <= ln_q[pick_q] - size_q;
					end else begin
						st_q[ii] <= st_q[ii-1'b1];
						ln_q[ii] <= ln_q[ii-1'b1];
					end
					i_q <= i_q - 1'b1;
				end
				S_SHIFT_DN: begin
					if (i_q + 1'b1 < cnt_q) begin
						st_q[ii] <= st_q[ii+1'b1];
						ln_q[ii] <= ln_q[ii+1'b1];
						ow_q[ii] <= ow_q[ii+1'b1];
						used_q[ii] <= used_q[ii+1'b1];
					end else begin
						st_q[ii] <= '0;
						ln_q[ii] <= '0;
						ow_q[ii] <= '0;
						used_q[ii] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
					end
					i_q <= i_q + 1'b1;
				end
				S_MERGE: begin
					mphase_q <= 1'b1;
					if (merge_right) begin
						ln_q[pick_q] <= ln_q[pick_q] + ln_q[pick_q+1'b1];
						i_q <= CW'(pick_q) + 1'b1;
					end else if (merge_left) begin
						ln_q[pick_q-1'b1] <= ln_q[pick_q-1'b1] + ln_q[pick_q];
						i_q <= CW'(pick_q);
						pick_q <= '0;
					end
				end
				S_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = stat_q;
	assign address = (stat_q == ST_OK) ? addr_q : 16'd0;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CMAX) else $error("segment count out of range");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");
	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> address == 16'd0) else $error("address on error");
endmodule
